@@ hdl/cruise_spacing_controller_assert.svh @@
// ----------------------------------------------------------------------------
// cruise spacing controller assertion macros
// shared property shapes for the checks in the controller rtl
// ----------------------------------------------------------------------------
`ifndef CRUISE_SPACING_CONTROLLER_ASSERT_SVH
`define CRUISE_SPACING_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSC_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CSC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/csc_pkg.sv @@
// ----------------------------------------------------------------------------
// csc_pkg
// constants, register indexes and datapath widths of the spacing controller
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package csc_pkg;

  // fixed point formats
  localparam int FRACTION_BITS = 8;
  localparam int GAIN_BITS     = 16;

  // datapath widths
  localparam int MUL_A_W = 24;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SAFE_W  = 22;
  localparam int ACC_W   = 26;
  localparam int SERR_W  = 18;

  // limits in signal units
  localparam logic [18:0] RANGE_LIMIT     = 19'(200 << FRACTION_BITS);
  localparam logic [15:0] ENGAGE_SPEED    = 16'(11 << FRACTION_BITS);
  localparam logic [15:0] SET_SPEED_LIMIT = 16'(120 << FRACTION_BITS);
  localparam logic [19:0] SAFE_MAX        = 20'hFFFFF;

  // register reset values
  localparam logic [15:0]        RST_SET_SPEED      = 16'd25600;
  localparam logic [15:0]        RST_SPEED_GAIN     = 16'd32768;
  localparam logic [15:0]        RST_DISTANCE_GAIN  = 16'd1311;
  localparam logic [15:0]        RST_CLOSING_GAIN   = 16'd2621;
  localparam logic [15:0]        RST_STANDSTILL     = 16'd2560;
  localparam logic [11:0]        RST_HEADWAY        = 12'd768;
  localparam logic signed [12:0] RST_ACCEL_MIN      = -13'sd1280;
  localparam logic [11:0]        RST_ACCEL_MAX      = 12'd376;

  // register indexes
  localparam logic [2:0] REG_SET_SPEED      = 3'd0;
  localparam logic [2:0] REG_SPEED_GAIN     = 3'd1;
  localparam logic [2:0] REG_DISTANCE_GAIN  = 3'd2;
  localparam logic [2:0] REG_CLOSING_GAIN   = 3'd3;
  localparam logic [2:0] REG_STANDSTILL     = 3'd4;
  localparam logic [2:0] REG_HEADWAY        = 3'd5;
  localparam logic [2:0] REG_ACCEL_MIN      = 3'd6;
  localparam logic [2:0] REG_ACCEL_MAX      = 3'd7;

endpackage

@@ hdl/cruise_spacing_controller.sv @@
// ----------------------------------------------------------------------------
// cruise_spacing_controller
// sequence: an accepted beat steps through MUL_SAFE, MUL_CLOSE, MUL_DIST, MUL_SPEED
//   and FINISH on the one shared 24x17 multiplier, which forms four products in turn;
//   the next beat is taken only as the result leaves FINISH, once the output is free
// reset: synchronous active-low, configuration registers return to defaults, latch clears
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "cruise_spacing_controller_assert.svh"

module cruise_spacing_controller (
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [15:0]        in_ego_velocity,
  input  logic signed [18:0] in_relative_distance,
  input  logic signed [16:0] in_relative_velocity,
  input  logic               in_acc_request,
  input  logic               in_rain,
  input  logic               in_gas_pedal,
  input  logic               in_brake_pedal,
  input  logic               in_fault,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [12:0] out_acceleration,
  output logic               out_engaged,
  output logic [19:0]        out_safe_spacing
);

  // sequencer codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_MUL_SAFE  = 3'd1;
  localparam logic [2:0] ST_MUL_CLOSE = 3'd2;
  localparam logic [2:0] ST_MUL_DIST  = 3'd3;
  localparam logic [2:0] ST_MUL_SPEED = 3'd4;
  localparam logic [2:0] ST_FINISH    = 3'd5;

  // configuration registers
  logic [15:0]        set_speed_r;
  logic [15:0]        speed_gain_r;
  logic [15:0]        distance_gain_r;
  logic [15:0]        closing_gain_r;
  logic [15:0]        standstill_r;
  logic [11:0]        headway_r;
  logic signed [12:0] accel_min_r;
  logic [11:0]        accel_max_r;

  // control
  logic [2:0] state_r, state_nxt;
  logic       latch_r, latch_nxt;
  logic       in_fire, out_free, done_ok;

  // captured beat and datapath registers
  logic [15:0]                         ego_r;
  logic signed [18:0]                  rd_r;
  logic signed [16:0]                  rv_r;
  logic [12:0]                         tg_r;
  logic                                engaged_r;
  logic signed [csc_pkg::PROD_W-1:0]   prod_r;
  logic [csc_pkg::SAFE_W-1:0]          safe_r;
  logic signed [csc_pkg::ACC_W-1:0]    cx_r;
  logic                                diff_pos_r;

  // output registers
  logic               out_valid_r;
  logic signed [12:0] out_acc_r;
  logic               out_engaged_r;
  logic [19:0]        out_safe_r;

  // combinational datapath
  logic signed [csc_pkg::MUL_A_W-1:0] mul_a;
  logic signed [csc_pkg::MUL_B_W-1:0] mul_b;
  logic signed [csc_pkg::PROD_W-1:0]  mul_p;
  logic signed [csc_pkg::ACC_W-1:0]   prod_term;
  logic signed [csc_pkg::MUL_A_W-1:0] diff;
  logic [15:0]                        sset;
  logic signed [csc_pkg::SERR_W-1:0]  spd_err;
  logic signed [csc_pkg::ACC_W-1:0]   acc_sel;
  logic signed [csc_pkg::ACC_W-1:0]   amin_ext;
  logic signed [csc_pkg::ACC_W-1:0]   amax_ext;
  logic signed [12:0]                 acc_clamped;
  logic [19:0]                        safe_sat;
  logic [18:0]                        rd_clamped;
  logic                               engage_ok;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign done_ok  = (state_r == ST_FINISH) && out_free;
  assign in_stall = !((state_r == ST_IDLE) || done_ok);
  assign in_fire  = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_speed_r     <= csc_pkg::RST_SET_SPEED;
      speed_gain_r    <= csc_pkg::RST_SPEED_GAIN;
      distance_gain_r <= csc_pkg::RST_DISTANCE_GAIN;
      closing_gain_r  <= csc_pkg::RST_CLOSING_GAIN;
      standstill_r    <= csc_pkg::RST_STANDSTILL;
      headway_r       <= csc_pkg::RST_HEADWAY;
      accel_min_r     <= csc_pkg::RST_ACCEL_MIN;
      accel_max_r     <= csc_pkg::RST_ACCEL_MAX;
    end else if (cfg_we) begin
      case (cfg_index)
        csc_pkg::REG_SET_SPEED:     set_speed_r     <= cfg_wdata;
        csc_pkg::REG_SPEED_GAIN:    speed_gain_r    <= cfg_wdata;
        csc_pkg::REG_DISTANCE_GAIN: distance_gain_r <= cfg_wdata;
        csc_pkg::REG_CLOSING_GAIN:  closing_gain_r  <= cfg_wdata;
        csc_pkg::REG_STANDSTILL:    standstill_r    <= cfg_wdata;
        csc_pkg::REG_HEADWAY:       headway_r       <= cfg_wdata[11:0];
        csc_pkg::REG_ACCEL_MIN:     accel_min_r     <= $signed(cfg_wdata[12:0]);
        csc_pkg::REG_ACCEL_MAX:     accel_max_r     <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // engage latch update for the incoming beat
  assign engage_ok = in_acc_request && !in_fault && !in_gas_pedal && !in_brake_pedal;
  always_comb begin
    latch_nxt = latch_r;
    if (in_fire) begin
      if (!latch_r && engage_ok && (in_ego_velocity >= csc_pkg::ENGAGE_SPEED)) begin
        latch_nxt = 1'b1;
      end else if (latch_r && engage_ok) begin
        latch_nxt = 1'b1;
      end else begin
        latch_nxt = 1'b0;
      end
    end
  end

  // range clamp on the lead distance
  assign rd_clamped = (in_relative_distance > $signed(csc_pkg::RANGE_LIMIT)) ?
                      csc_pkg::RANGE_LIMIT : in_relative_distance;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (in_fire) state_nxt = ST_MUL_SAFE;
      ST_MUL_SAFE:  state_nxt = ST_MUL_CLOSE;
      ST_MUL_CLOSE: state_nxt = ST_MUL_DIST;
      ST_MUL_DIST:  state_nxt = ST_MUL_SPEED;
      ST_MUL_SPEED: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (in_fire) state_nxt = ST_MUL_SAFE;
        else if (done_ok) state_nxt = ST_IDLE;
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      latch_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      latch_r <= latch_nxt;
    end
  end

  // operand terms
  assign diff    = $signed({2'b00, safe_r}) - csc_pkg::MUL_A_W'(rd_r);
  assign sset    = (set_speed_r > csc_pkg::SET_SPEED_LIMIT) ?
                   csc_pkg::SET_SPEED_LIMIT : set_speed_r;
  assign spd_err = $signed({2'b00, sset}) - $signed({2'b00, ego_r});

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      ST_MUL_SAFE: begin
        mul_a = $signed({8'd0, ego_r});
        mul_b = $signed({4'd0, tg_r});
      end
      ST_MUL_CLOSE: begin
        mul_a = csc_pkg::MUL_A_W'(rv_r);
        mul_b = $signed({1'b0, closing_gain_r});
      end
      ST_MUL_DIST: begin
        mul_a = diff;
        mul_b = $signed({1'b0, distance_gain_r});
      end
      ST_MUL_SPEED: begin
        mul_a = csc_pkg::MUL_A_W'(spd_err);
        mul_b = $signed({1'b0, speed_gain_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p     = mul_a * mul_b;
  assign prod_term = csc_pkg::ACC_W'(prod_r >>> csc_pkg::GAIN_BITS);

  // capture and accumulate
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ego_r     <= in_ego_velocity;
      rd_r      <= $signed(rd_clamped);
      rv_r      <= in_relative_velocity;
      tg_r      <= in_rain ? {headway_r, 1'b0} : {1'b0, headway_r};
      engaged_r <= latch_nxt;
    end
    // speed product holds while the result waits
    if (state_r != ST_FINISH) prod_r <= mul_p;
    case (state_r)
      ST_MUL_CLOSE: begin
        safe_r <= csc_pkg::SAFE_W'(prod_r >>> csc_pkg::FRACTION_BITS)
                  + csc_pkg::SAFE_W'(standstill_r);
      end
      ST_MUL_DIST: begin
        cx_r       <= prod_term;
        diff_pos_r <= diff > 0;
      end
      ST_MUL_SPEED: cx_r <= cx_r - prod_term;
      default: ;
    endcase
  end

  // command select and limit clamp
  assign amin_ext = csc_pkg::ACC_W'(accel_min_r);
  assign amax_ext = $signed({{(csc_pkg::ACC_W-12){1'b0}}, accel_max_r});
  assign acc_sel  = diff_pos_r ? cx_r : ((cx_r < prod_term) ? cx_r : prod_term);

  always_comb begin
    if (acc_sel < amin_ext) acc_clamped = accel_min_r;
    else if (acc_sel > amax_ext) acc_clamped = $signed({1'b0, accel_max_r});
    else acc_clamped = acc_sel[12:0];
  end

  assign safe_sat = (safe_r > csc_pkg::SAFE_W'(csc_pkg::SAFE_MAX)) ?
                    csc_pkg::SAFE_MAX : safe_r[19:0];

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_ok) begin
      out_acc_r     <= acc_clamped;
      out_engaged_r <= engaged_r;
      out_safe_r    <= safe_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_acceleration  = out_acc_r;
  assign out_engaged       = out_engaged_r;
  assign out_safe_spacing  = out_safe_r;

  // checks
  `CSC_ASSERT_NEXT(a_fire_starts_seq, in_fire, state_r == ST_MUL_SAFE, "beat did not start sequence")
  `CSC_ASSERT_SAME(a_result_from_finish, $rose(out_valid_r), $past(state_r == ST_FINISH), "result beat without finish step")
  `CSC_ASSERT_SAME(a_acc_in_limits, out_valid_r && (amin_ext <= amax_ext), (out_acc_r >= accel_min_r) && (csc_pkg::ACC_W'(out_acc_r) <= amax_ext), "command outside limits")
  `CSC_ASSERT_SAME(a_busy_stalls, (state_r != ST_IDLE) && (state_r != ST_FINISH), in_stall, "beat taken mid sequence")

endmodule

@@ dv/cruise_spacing_controller_test.sv @@
// ----------------------------------------------------------------------------
// cruise_spacing_controller_test
// self-checking bench for the spacing controller: drives control ticks with
// random handshake gaps and stalls, predicts each command beat in a
// scoreboard and compares every field of every result beat in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cruise_spacing_controller_test;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 120;
  localparam int SETTLE_CYCLES  = 12;

  // one control tick and one command beat
  typedef struct packed {
    logic [15:0]        ego;
    logic signed [18:0] distance;
    logic signed [16:0] closing;
    logic               request;
    logic               rain;
    logic               gas;
    logic               brake;
    logic               fault;
  } tick_t;

  typedef struct packed {
    logic [12:0] accel;
    logic        engaged;
    logic [19:0] safe;
  } command_t;

  // --------------------------------------------------------------------------
  // scoreboard: shadow registers, engage latch and pending commands
  // --------------------------------------------------------------------------
  class spacing_scoreboard;
    longint   set_speed, speed_gain, distance_gain, closing_gain;
    longint   standstill, headway, accel_min, accel_max;
    bit       latch;
    command_t pending[$];
    int       mismatches;
    int       results_seen;

    function new();
      restore_defaults();
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void restore_defaults();
      set_speed     = csc_pkg::RST_SET_SPEED;
      speed_gain    = csc_pkg::RST_SPEED_GAIN;
      distance_gain = csc_pkg::RST_DISTANCE_GAIN;
      closing_gain  = csc_pkg::RST_CLOSING_GAIN;
      standstill    = csc_pkg::RST_STANDSTILL;
      headway       = csc_pkg::RST_HEADWAY;
      accel_min     = longint'(csc_pkg::RST_ACCEL_MIN);
      accel_max     = csc_pkg::RST_ACCEL_MAX;
      latch         = 1'b0;
    endfunction

    function void write_reg(logic [2:0] index, logic [15:0] value);
      case (index)
        csc_pkg::REG_SET_SPEED:     set_speed = value;
        csc_pkg::REG_SPEED_GAIN:    speed_gain = value;
        csc_pkg::REG_DISTANCE_GAIN: distance_gain = value;
        csc_pkg::REG_CLOSING_GAIN:  closing_gain = value;
        csc_pkg::REG_STANDSTILL:    standstill = value;
        csc_pkg::REG_HEADWAY:       headway = value[11:0];
        csc_pkg::REG_ACCEL_MIN:     accel_min = longint'($signed(value[12:0]));
        csc_pkg::REG_ACCEL_MAX:     accel_max = value[11:0];
        default: ;
      endcase
    endfunction

    // engage latch, safe spacing and clamped command for one tick
    function command_t predict_command(tick_t t);
      longint   ego, lead_dist, closing, gap, target, safe, diff;
      longint   spacing_term, speed_term, accel;
      longint   range_cap, speed_cap, engage_speed, safe_cap;
      bit       active;
      command_t c;
      range_cap    = csc_pkg::RANGE_LIMIT;
      speed_cap    = csc_pkg::SET_SPEED_LIMIT;
      engage_speed = csc_pkg::ENGAGE_SPEED;
      safe_cap     = csc_pkg::SAFE_MAX;
      ego          = t.ego;
      lead_dist    = longint'($signed(t.distance));
      closing      = longint'($signed(t.closing));
      // only the far side of the sensor range is clamped
      if (lead_dist > range_cap) lead_dist = range_cap;
      if (!latch && t.request && !t.fault && ego >= engage_speed && !t.gas && !t.brake) begin
        latch  = 1'b1;
        active = 1'b1;
      end else if (t.request && latch && !t.fault && !t.gas && !t.brake) begin
        active = 1'b1;
      end else begin
        latch  = 1'b0;
        active = 1'b0;
      end
      gap    = t.rain ? 2 * headway : headway;
      target = (set_speed > speed_cap) ? speed_cap : set_speed;
      safe   = ((ego * gap) >>> csc_pkg::FRACTION_BITS) + standstill;
      diff   = safe - lead_dist;
      spacing_term = ((closing * closing_gain) >>> csc_pkg::GAIN_BITS)
                   - ((diff * distance_gain) >>> csc_pkg::GAIN_BITS);
      speed_term   = ((target - ego) * speed_gain) >>> csc_pkg::GAIN_BITS;
      // inside the safe spacing the spacing term rules alone
      if (diff > 0) accel = spacing_term;
      else accel = (spacing_term < speed_term) ? spacing_term : speed_term;
      // lower limit checked first, so it wins when the limits cross
      if (accel < accel_min) accel = accel_min;
      else if (accel > accel_max) accel = accel_max;
      c.accel   = accel[12:0];
      c.engaged = active;
      c.safe    = (safe > safe_cap) ? safe_cap[19:0] : safe[19:0];
      return c;
    endfunction

    function void note_tick(tick_t t);
      pending.push_back(predict_command(t));
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch on result %0d: %s", $time, results_seen, what);
      mismatches++;
    endtask

    task check_command(command_t got);
      command_t want;
      results_seen++;
      if (pending.size() == 0) begin
        report_mismatch("result beat with no command pending");
        return;
      end
      want = pending.pop_front();
      if (got.accel !== want.accel)
        report_mismatch($sformatf("acceleration got %0d expected %0d",
                                  $signed(got.accel), $signed(want.accel)));
      if (got.engaged !== want.engaged)
        report_mismatch($sformatf("engaged got %0b expected %0b",
                                  got.engaged, want.engaged));
      if (got.safe !== want.safe)
        report_mismatch($sformatf("safe spacing got %0d expected %0d",
                                  got.safe, want.safe));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // signals and block under test
  // --------------------------------------------------------------------------
  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [15:0]        in_ego_velocity;
  logic signed [18:0] in_relative_distance;
  logic signed [16:0] in_relative_velocity;
  logic               in_acc_request;
  logic               in_rain;
  logic               in_gas_pedal;
  logic               in_brake_pedal;
  logic               in_fault;
  logic               out_valid;
  logic               out_stall;
  logic signed [12:0] out_acceleration;
  logic               out_engaged;
  logic [19:0]        out_safe_spacing;

  spacing_scoreboard sb = new();

  bit sender_gaps;
  bit receiver_bursts;
  bit long_hold_req;
  int quiet_cycles;

  cruise_spacing_controller uut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // result side: stall bursts, quiet stretches and one long hold
  // --------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall     <= 1'b0;
        long_hold_req = 1'b0;
      end else if (receiver_bursts && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        // stretch with no stall at all
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // check every accepted result beat
  always @(posedge clk) begin : result_monitor
    command_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.accel   = out_acceleration;
      got.engaged = out_engaged;
      got.safe    = out_safe_spacing;
      sb.check_command(got);
    end
  end

  // watchdog on cycles with no beat accepted on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("cruise_spacing_controller_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tick_t mk_tick(logic [15:0] ego, logic signed [18:0] lead_dist,
                                    logic signed [16:0] closing, bit req, bit rain,
                                    bit gas, bit brake, bit fault);
    tick_t t;
    t.ego      = ego;
    t.distance = lead_dist;
    t.closing  = closing;
    t.request  = req;
    t.rain     = rain;
    t.gas      = gas;
    t.brake    = brake;
    t.fault    = fault;
    return t;
  endfunction

  // steady ticks hold the request with rare pedal or fault events
  function automatic tick_t random_tick(bit steady);
    tick_t t;
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: t.ego = 16'd0;
           1: t.ego = 16'hFFFF;
           2: t.ego = csc_pkg::ENGAGE_SPEED - 16'd1;
           3: t.ego = csc_pkg::ENGAGE_SPEED;
           default: t.ego = csc_pkg::ENGAGE_SPEED + 16'd1;
         endcase
      1, 2, 3, 4, 5, 6: t.ego = 16'($urandom_range(0, 12800));
      default: t.ego = 16'($urandom);
    endcase
    case ($urandom_range(0, 9))
      0: case ($urandom_range(0, 4))
           0: t.distance = -19'sd262144;
           1: t.distance = 19'sd262143;
           2: t.distance = csc_pkg::RANGE_LIMIT;
           3: t.distance = csc_pkg::RANGE_LIMIT + 19'd1;
           default: t.distance = -19'sd1;
         endcase
      1, 2, 3, 4, 5, 6: t.distance = 19'($urandom_range(0, 40000));
      7: t.distance = 19'(-$urandom_range(1, 5000));
      default: t.distance = 19'($urandom);
    endcase
    if ($urandom_range(0, 9) < 7) t.closing = 17'($urandom_range(0, 4096) - 2048);
    else t.closing = 17'($urandom);
    if (steady) begin
      t.request = $urandom_range(0, 19) != 0;
      t.gas     = $urandom_range(0, 29) == 0;
      t.brake   = $urandom_range(0, 29) == 0;
      t.fault   = $urandom_range(0, 49) == 0;
    end else begin
      t.request = $urandom_range(0, 1);
      t.gas     = $urandom_range(0, 1);
      t.brake   = $urandom_range(0, 1);
      t.fault   = $urandom_range(0, 1);
    end
    t.rain = $urandom_range(0, 1);
    return t;
  endfunction

  // drive one tick and hold it until the beat is taken
  task automatic send_tick(tick_t t);
    @(negedge clk);
    in_valid             <= 1'b1;
    in_ego_velocity      <= t.ego;
    in_relative_distance <= t.distance;
    in_relative_velocity <= t.closing;
    in_acc_request       <= t.request;
    in_rain              <= t.rain;
    in_gas_pedal         <= t.gas;
    in_brake_pedal       <= t.brake;
    in_fault             <= t.fault;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(t);
  endtask

  task automatic idle_sender(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // stop sending and wait for every pending command to come out
  task automatic drain_results();
    idle_sender(1);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [2:0] index, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    sb.write_reg(index, value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_all(logic [15:0] set_speed, logic [15:0] speed_gain,
                             logic [15:0] distance_gain, logic [15:0] closing_gain,
                             logic [15:0] standstill, logic [11:0] headway,
                             logic signed [12:0] accel_min, logic [11:0] accel_max);
    drain_results();
    write_register(csc_pkg::REG_SET_SPEED, set_speed);
    write_register(csc_pkg::REG_SPEED_GAIN, speed_gain);
    write_register(csc_pkg::REG_DISTANCE_GAIN, distance_gain);
    write_register(csc_pkg::REG_CLOSING_GAIN, closing_gain);
    write_register(csc_pkg::REG_STANDSTILL, standstill);
    write_register(csc_pkg::REG_HEADWAY, {4'd0, headway});
    write_register(csc_pkg::REG_ACCEL_MIN, {{3{accel_min[12]}}, accel_min});
    write_register(csc_pkg::REG_ACCEL_MAX, {4'd0, accel_max});
  endtask

  task automatic program_random();
    program_all($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 32000)),
                16'($urandom),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8000)),
                $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 8000)),
                16'($urandom),
                12'($urandom),
                13'(-$urandom_range(0, 4096)),
                12'($urandom_range(0, 4095)));
  endtask

  // runs of steady cruising or noisy flags, with optional sender gaps
  task automatic run_traffic(int count);
    int sent;
    int run_len;
    bit steady;
    bit gaps_here;
    sent = 0;
    while (sent < count) begin
      run_len   = $urandom_range(5, 30);
      steady    = $urandom_range(0, 3) != 0;
      gaps_here = sender_gaps && $urandom_range(0, 2) != 0;
      repeat (run_len) begin
        if (gaps_here && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 11));
        send_tick(random_tick(steady));
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = csc_pkg::REG_SET_SPEED;
    cfg_wdata            = 16'd0;
    in_valid             = 1'b0;
    in_ego_velocity      = 16'd0;
    in_relative_distance = 19'sd0;
    in_relative_velocity = 17'sd0;
    in_acc_request       = 1'b0;
    in_rain              = 1'b0;
    in_gas_pedal         = 1'b0;
    in_brake_pedal       = 1'b0;
    in_fault             = 1'b0;
    sender_gaps          = 1'b1;
    receiver_bursts      = 1'b1;
    long_hold_req        = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset settings
    send_tick(mk_tick(16'd0, 19'sd0, 17'sd0, 0, 0, 0, 0, 0));
    // just under the engage speed, then exactly at it with distance past range
    send_tick(mk_tick(csc_pkg::ENGAGE_SPEED - 16'd1, 19'sd20000, 17'sd0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(csc_pkg::ENGAGE_SPEED, 19'sd262143, 17'sd0, 1, 0, 0, 0, 0));
    // latch holds at standstill, then gas drops it
    send_tick(mk_tick(16'd0, 19'sd5000, 17'sd100, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd3000, 19'sd5000, 17'sd100, 1, 0, 1, 0, 0));
    // top speed, negative distance, fastest closing
    send_tick(mk_tick(16'hFFFF, -19'sd262144, -17'sd65536, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd5000, 19'sd30000, 17'sd0, 1, 0, 0, 1, 0));
    send_tick(mk_tick(16'd5000, csc_pkg::RANGE_LIMIT + 19'd1, 17'sd65535, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd5000, 19'sd30000, 17'sd0, 1, 0, 0, 0, 1));
    send_tick(mk_tick(16'd5000, 19'sd30000, 17'sd0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd5000, 19'sd30000, 17'sd0, 0, 0, 0, 0, 0));
    // rain doubles the gap, distance right at the range limit and below it
    send_tick(mk_tick(16'd10000, csc_pkg::RANGE_LIMIT, -17'sd300, 1, 1, 0, 0, 0));
    send_tick(mk_tick(16'd10000, csc_pkg::RANGE_LIMIT - 19'd1, 17'sd300, 1, 0, 0, 0, 0));
    // spacing error of zero and of one either way: 10 m/s gives 40 m
    send_tick(mk_tick(16'd2560, 19'sd10240, 17'sd0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd2560, 19'sd10241, 17'sd0, 1, 0, 0, 0, 0));
    send_tick(mk_tick(16'd2560, 19'sd10239, 17'sd0, 1, 0, 0, 0, 0));
    // every flag at once
    send_tick(mk_tick(16'hFFFF, 19'sd262143, 17'sd65535, 1, 1, 1, 1, 1));

    // long receiver hold while the sender keeps offering beats
    drain_results();
    long_hold_req = 1'b1;
    repeat (24) send_tick(random_tick(1'b1));
    run_traffic(200);

    // everything at its top, set speed far above the clamp
    program_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'hFFF,
                -13'sd4096, 12'hFFF);
    send_tick(mk_tick(16'hFFFF, 19'sd0, 17'sd0, 1, 1, 0, 0, 0));
    run_traffic(200);

    // everything at zero
    program_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 12'd0, 13'sd0, 12'd0);
    run_traffic(200);

    // crossed limits: the lower bound sits above the upper bound
    program_all(16'd31000, 16'd32768, 16'd1311, 16'd2621, 16'd2560, 12'd768,
                13'sd300, 12'd100);
    run_traffic(200);

    program_random();
    run_traffic(200);

    // sender pause until every command is back
    program_random();
    run_traffic(100);
    drain_results();
    run_traffic(100);

    program_random();
    run_traffic(200);

    // closing part with no idling on either side
    program_random();
    sender_gaps     = 1'b0;
    receiver_bursts = 1'b0;
    run_traffic(200);

    drain_results();
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("cruise_spacing_controller_test OK");
    end else begin
      $display("cruise_spacing_controller_test NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/csc_pkg.sv
hdl/cruise_spacing_controller.sv
dv/cruise_spacing_controller_test.sv
